/* rtl/rprp_pkg.sv */
// ----------------------------------------------------------------------------
// rprp_pkg
// shared constants, types and helpers for the parity repair unpacker
// ----------------------------------------------------------------------------
package rprp_pkg;

   localparam int MAX_DISKS_DEF   = 6;
   localparam int MAX_SEGMENT_DEF = 64;

   // fixed field widths
   localparam int DISK_W    = 3;   // disk_count register, disk_number field
   localparam int DCNT_W    = 4;   // internal disk count / index, holds up to 15
   localparam int SEG_CFG_W = 7;   // segment_bits register
   localparam int CSR_W     = 7;   // widest register
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ODD_PARITY   = 2'd2;

   localparam logic [DISK_W-1:0]    DISK_COUNT_RST   = 3'd6;
   localparam logic [SEG_CFG_W-1:0] SEGMENT_BITS_RST = 7'd8;

   // what the merge stage found across the lanes for one column
   typedef struct packed {
      logic none_lost;
      logic one_lost;
      logic parity;     // xor of the known bits of the live disks
   } rprp_merge_type;

   // block-end snapshot control handed to the emitter
   typedef struct packed {
      logic [DISK_W-1:0]    parity_disk;
      logic [DCNT_W-1:0]    disk_count;
      logic [SEG_CFG_W-1:0] shift;
      logic [SEG_CFG_W-1:0] seg_bits;
      logic                 set_ok;
      logic                 last;
   } rprp_snap_type;

   // stored parity index reduced by the live disk count (value < 8, count >= 2)
   function automatic logic [DISK_W-1:0] pd_mod(input logic [DISK_W-1:0] v,
                                                input logic [DCNT_W-1:0] d);
      logic [DCNT_W-1:0] r;
      r = DCNT_W'(v);
      for (int i = 0; i < 4; i++) begin
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[DISK_W-1:0];
   endfunction

endpackage

/* rtl/rprp_lane.sv */
// ----------------------------------------------------------------------------
// rprp_lane
// one disk: masks its bit, takes the rebuilt bit, holds its segment register
// ----------------------------------------------------------------------------
module rprp_lane
   import rprp_pkg::*;
#(
   parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   live,       // disk index below disk count
   input  logic                   col_bit,
   input  logic                   unknown,
   input  logic                   shift_en,
   input  logic                   clear,      // block end, start fresh
   input  logic                   fix_en,     // exactly one lost bit in column
   input  logic                   fix_val,
   output logic                   lost,
   output logic                   known,      // contribution to the column xor
   output logic [MAX_SEGMENT-1:0] seg_next
);

   logic [MAX_SEGMENT-1:0] seg_ff, seg_in;
   logic                   bit_store;

   assign lost      = live & unknown;
   assign known     = live & ~unknown & col_bit;
   // lost bits go in as zero unless they can be rebuilt
   assign bit_store = lost ? (fix_en & fix_val) : col_bit;
   assign seg_next  = (seg_ff << 1) | MAX_SEGMENT'(bit_store);

   always_comb begin
      seg_in = seg_ff;
      if (shift_en) begin
         seg_in = clear ? '0 : seg_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else begin
         seg_ff <= seg_in;
      end
   end

endmodule

/* rtl/rprp_merge.sv */
// ----------------------------------------------------------------------------
// rprp_merge
// combines the lane results: lost count class and column parity
// ----------------------------------------------------------------------------
module rprp_merge
   import rprp_pkg::*;
#(
   parameter int MAX_DISKS = MAX_DISKS_DEF
) (
   input  logic [MAX_DISKS-1:0] lost,
   input  logic [MAX_DISKS-1:0] known,
   output rprp_merge_type       merged
);

   always_comb begin
      merged.none_lost = (lost == '0);
      merged.one_lost  = $onehot(lost);
      merged.parity    = ^known;
   end

endmodule

/* rtl/rprp_emit.sv */
// ----------------------------------------------------------------------------
// rprp_emit
// holds one block snapshot and sends one data disk segment per cycle while rsp_stall is low
// ----------------------------------------------------------------------------
module rprp_emit
   import rprp_pkg::*;
#(
   parameter int MAX_DISKS   = MAX_DISKS_DEF,
   parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   snap_load,
   input  rprp_snap_type          snap,
   input  logic [MAX_SEGMENT-1:0] snap_segs [MAX_DISKS],
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [MAX_SEGMENT-1:0] rsp_segment,
   output logic [DISK_W-1:0]      rsp_disk_number,
   output logic                   rsp_set_valid,
   output logic                   rsp_last_of_block,
   output logic                   rsp_last_of_set
);

   localparam int LIDX_W = $clog2(MAX_DISKS);

   logic [MAX_SEGMENT-1:0] segs_ff [MAX_DISKS];
   rprp_snap_type          snap_ff;
   logic                   busy_ff, busy_in;
   logic [DCNT_W-1:0]      idx_ff, idx_in, idx_nxt;
   logic                   is_last, out_free, take;

   logic                   valid_ff, valid_in;
   logic [MAX_SEGMENT-1:0] seg_ff, seg_in, seg_sel, seg_mask;
   logic [DISK_W-1:0]      num_ff, num_in;
   logic                   ok_ff, ok_in, lob_ff, lob_in, los_ff, los_in;

   // next data disk, stepping over the parity disk
   always_comb begin
      idx_nxt = idx_ff + DCNT_W'(1);
      if (idx_nxt == DCNT_W'(snap_ff.parity_disk)) begin
         idx_nxt = idx_ff + DCNT_W'(2);
      end
      is_last = (idx_nxt >= snap_ff.disk_count);
   end

   assign out_free = ~valid_ff | ~rsp_stall;
   assign take     = busy_ff & out_free;

   // align partial blocks and trim to the segment length
   assign seg_sel  = segs_ff[idx_ff[LIDX_W-1:0]] << snap_ff.shift;
   assign seg_mask = ~({MAX_SEGMENT{1'b1}} << snap_ff.seg_bits);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (snap_load) begin
         busy_in = 1'b1;
         idx_in  = (snap.parity_disk == '0) ? DCNT_W'(1) : '0;
      end else if (take) begin
         busy_in = ~is_last;
         idx_in  = idx_nxt;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      seg_in   = seg_ff;
      num_in   = num_ff;
      ok_in    = ok_ff;
      lob_in   = lob_ff;
      los_in   = los_ff;
      if (out_free) begin
         valid_in = busy_ff;
         seg_in   = seg_sel & seg_mask;
         num_in   = idx_ff[DISK_W-1:0];
         ok_in    = snap_ff.set_ok;
         lob_in   = is_last;
         los_in   = is_last & snap_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_ff <= snap;
         segs_ff <= snap_segs;
      end
      seg_ff <= seg_in;
      num_ff <= num_in;
      ok_ff  <= ok_in;
      lob_ff <= lob_in;
      los_ff <= los_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_segment       = seg_ff;
   assign rsp_disk_number   = num_ff;
   assign rsp_set_valid     = ok_ff;
   assign rsp_last_of_block = lob_ff;
   assign rsp_last_of_set   = los_ff;

`ifndef ASSERT_OFF
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      snap_load |-> !busy_ff)
      else $error("snapshot loaded while previous block still sending");

   a_idx_data_disk: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff != DCNT_W'(snap_ff.parity_disk)) &&
                  (idx_ff < snap_ff.disk_count))
      else $error("emit index on parity disk or beyond disk count");

   a_set_end_is_block_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && los_ff |-> lob_ff)
      else $error("set end word without block end");
`endif

endmodule

/* rtl/raid_parity_repair_unpack.sv */
// ----------------------------------------------------------------------------
// raid_parity_repair_unpack
// xor parity single erasure repair, per-disk segment unpacking
// ----------------------------------------------------------------------------
//  channel  dir  handshake          word
//  req_     in   valid / stall      one bit column across the disks
//  rsp_     out  valid / stall      one repaired data disk segment
//  csr_     in   write / index      disk_count, segment_bits, odd_parity
//
//  one column per cycle, barring stalls; lanes repair and shift it in that cycle
//  a block end yields disk_count-1 words, one per cycle from the snapshot
//  register unless stalled; the next block's columns keep flowing meanwhile
//  a column that ends a block stalls while the previous block is still sending
//  reset is synchronous; lane segments, counts and parity clear in a reset cycle
// ----------------------------------------------------------------------------
module raid_parity_repair_unpack
   import rprp_pkg::*;
#(
   parameter int MAX_DISKS   = MAX_DISKS_DEF,
   parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_data,
   // column words
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MAX_DISKS-1:0]   req_column_bits,
   input  logic [MAX_DISKS-1:0]   req_unknown_mask,
   input  logic                   req_last_column,
   // segment words
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [MAX_SEGMENT-1:0] rsp_segment,
   output logic [DISK_W-1:0]      rsp_disk_number,
   output logic                   rsp_set_valid,
   output logic                   rsp_last_of_block,
   output logic                   rsp_last_of_set
);

   localparam int CNT_W = $clog2(MAX_SEGMENT + 1);

   // configuration registers
   logic [DISK_W-1:0]    disk_count_ff;
   logic [SEG_CFG_W-1:0] segment_bits_ff;
   logic                 odd_parity_ff;

   // set state
   logic [CNT_W-1:0]     col_ff, col_in;
   logic [DISK_W-1:0]    pd_ff, pd_in;
   logic                 set_ok_ff, set_ok_in;

   // clamped settings
   logic [DCNT_W-1:0]    d_eff;
   logic [SEG_CFG_W-1:0] s_eff;

   logic [CNT_W-1:0]     n;
   logic                 accept, block_end, fail, busy, fix_val;
   logic [DISK_W-1:0]    pd_cur, pd_inc;
   logic [MAX_DISKS-1:0] lost, known;
   logic [MAX_SEGMENT-1:0] seg_next [MAX_DISKS];
   rprp_merge_type       merged;
   rprp_snap_type        snap;

   // ---- configuration port --------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         disk_count_ff   <= DISK_COUNT_RST;
         segment_bits_ff <= SEGMENT_BITS_RST;
         odd_parity_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DISK_COUNT:   disk_count_ff   <= csr_data[DISK_W-1:0];
            CSR_SEGMENT_BITS: segment_bits_ff <= csr_data[SEG_CFG_W-1:0];
            CSR_ODD_PARITY:   odd_parity_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // out-of-range settings are clamped when used
   always_comb begin
      d_eff = DCNT_W'(disk_count_ff);
      if (d_eff < DCNT_W'(2)) begin
         d_eff = DCNT_W'(2);
      end else if (d_eff > DCNT_W'(MAX_DISKS)) begin
         d_eff = DCNT_W'(MAX_DISKS);
      end
      s_eff = segment_bits_ff;
      if (s_eff < SEG_CFG_W'(1)) begin
         s_eff = SEG_CFG_W'(1);
      end else if (s_eff > SEG_CFG_W'(MAX_SEGMENT)) begin
         s_eff = SEG_CFG_W'(MAX_SEGMENT);
      end
   end

   // ---- column handshake ----------------------------------------------------
   assign n         = col_ff + CNT_W'(1);
   assign block_end = (SEG_CFG_W'(n) >= s_eff) | req_last_column;
   // only a block-ending column has to wait for the snapshot register
   assign req_stall = busy & block_end;
   assign accept    = req_valid & ~req_stall;

   // ---- lanes ---------------------------------------------------------------
   assign fix_val = merged.parity ^ odd_parity_ff;

   for (genvar j = 0; j < MAX_DISKS; j++) begin : g_lane
      rprp_lane #(
         .MAX_SEGMENT (MAX_SEGMENT)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .live     (DCNT_W'(j) < d_eff),
         .col_bit  (req_column_bits[j]),
         .unknown  (req_unknown_mask[j]),
         .shift_en (accept),
         .clear    (block_end),
         .fix_en   (merged.one_lost),
         .fix_val  (fix_val),
         .lost     (lost[j]),
         .known    (known[j]),
         .seg_next (seg_next[j])
      );
   end

   rprp_merge #(
      .MAX_DISKS (MAX_DISKS)
   ) u_merge (
      .lost   (lost),
      .known  (known),
      .merged (merged)
   );

   // mismatch with nothing lost, or more than one lost bit
   assign fail = (merged.none_lost & (merged.parity != odd_parity_ff)) |
                 (~merged.none_lost & ~merged.one_lost);

   // ---- parity disk rotation ------------------------------------------------
   assign pd_cur = pd_mod(pd_ff, d_eff);
   assign pd_inc = ((DCNT_W'(pd_cur) + DCNT_W'(1)) == d_eff) ? '0 : pd_cur + DISK_W'(1);

   always_comb begin
      col_in    = col_ff;
      pd_in     = pd_ff;
      set_ok_in = set_ok_ff;
      if (accept) begin
         if (block_end && req_last_column) begin
            // set done, back to a fresh set
            col_in    = '0;
            pd_in     = '0;
            set_ok_in = 1'b1;
         end else if (block_end) begin
            col_in    = '0;
            pd_in     = pd_inc;
            set_ok_in = set_ok_ff & ~fail;
         end else begin
            col_in    = n;
            set_ok_in = set_ok_ff & ~fail;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         pd_ff     <= '0;
         set_ok_ff <= 1'b1;
      end else begin
         col_ff    <= col_in;
         pd_ff     <= pd_in;
         set_ok_ff <= set_ok_in;
      end
   end

   // ---- block snapshot and emission -----------------------------------------
   always_comb begin
      snap.parity_disk = pd_cur;
      snap.disk_count  = d_eff;
      // partial block: left-align to the segment length
      snap.shift       = (SEG_CFG_W'(n) < s_eff) ? s_eff - SEG_CFG_W'(n) : '0;
      snap.seg_bits    = s_eff;
      snap.set_ok      = set_ok_ff & ~fail;
      snap.last        = req_last_column;
   end

   rprp_emit #(
      .MAX_DISKS   (MAX_DISKS),
      .MAX_SEGMENT (MAX_SEGMENT)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .snap_load         (accept & block_end),
      .snap              (snap),
      .snap_segs         (seg_next),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_segment       (rsp_segment),
      .rsp_disk_number   (rsp_disk_number),
      .rsp_set_valid     (rsp_set_valid),
      .rsp_last_of_block (rsp_last_of_block),
      .rsp_last_of_set   (rsp_last_of_set)
   );

`ifndef ASSERT_OFF
   a_fail_sticks: assert property (@(posedge clock) disable iff (reset)
      accept && fail && !block_end |=> !set_ok_ff)
      else $error("failed column did not clear set ok");

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> busy)
      else $error("column stalled with emitter idle");

   a_col_advances: assert property (@(posedge clock) disable iff (reset)
      accept && !block_end |=> col_ff != '0)
      else $error("column count did not advance inside block");
`endif

endmodule
